### rtl/core/prtd_pkg.sv
// ----------------------------------------------------------------------------
// prtd_pkg
// Shared codes and types for the proximity rise trigger detector.
// ----------------------------------------------------------------------------
package prtd_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_WSIZE      = 2'd1;
  localparam logic [1:0] REG_USE_MEDIAN = 2'd2;
  localparam logic [1:0] REG_THRESHOLD  = 2'd3;

  // item modes
  localparam logic [1:0] MODE_PROX   = 2'd0;
  localparam logic [1:0] MODE_CHECK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // profiles
  localparam logic [2:0] PROF_NONE    = 3'd0;
  localparam logic [2:0] PROF_MOTION  = 3'd1;
  localparam logic [2:0] PROF_PROX    = 3'd2;
  localparam logic [2:0] PROF_EITHER  = 3'd3;
  localparam logic [2:0] PROF_BOTH    = 3'd4;

  typedef struct packed {
    logic start;
    logic use_median;
  } red_ctl_t;

endpackage

### rtl/core/prtd_if.sv
// ----------------------------------------------------------------------------
// prtd channel interfaces
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface prtd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  profile;
  logic [15:0] sample;
  logic        motion_seen;
  modport source (output valid, mode, profile, sample, motion_seen, input ready);
  modport sink   (input valid, mode, profile, sample, motion_seen, output ready);
endinterface

interface prtd_out_if;
  logic        valid;
  logic        ready;
  logic        proximity_triggered;
  logic        check_result;
  logic        sample_accepted;
  logic [15:0] baseline;
  modport source (output valid, proximity_triggered, check_result, sample_accepted,
                  baseline, input ready);
  modport sink   (input valid, proximity_triggered, check_result, sample_accepted,
                  baseline, output ready);
endinterface

### rtl/core/proximity_rise_trigger_detector_top.sv
// ----------------------------------------------------------------------------
// proximity_rise_trigger_detector_top
// Sliding window baseline and rise detector with confirmation set.
// ----------------------------------------------------------------------------
// Items arrive on in_if (mode, profile, sample, motion_seen) and each gives
// exactly one word on out_if. The user must see that registers are written on
// the cfg_ port only while the block is idle; the block does not enforce it.
// Items that need no reduction pass from S_IDLE through S_EMIT into the
// output register. A sample that closes a full window or a confirmation set
// runs the shared reduction unit (mean or median over the effective window
// size), whose one comparator/adder steps over the store. in_if.ready is
// high only while no item is in work.
// A finished word sits in the output register; the next item is accepted
// meanwhile, and its result waits until the receiver takes the first.
// Synchronous reset empties the window, clears the divider, trigger
// sources and confirmation, and loads the register defaults.
// ----------------------------------------------------------------------------
module proximity_rise_trigger_detector_top #(
  parameter int MAX_WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  prtd_in_if.sink     in_if,
  prtd_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN_W, S_RUN_C, S_EMIT} state_t;

  state_t        state_r;
  logic [7:0]    interval_r, icnt_r;
  logic [4:0]    wsize_r;
  logic          use_median_r;
  logic [15:0]   thresh_r;
  logic [15:0]   win_r  [MAX_WINDOW];
  logic [15:0]   conf_r [MAX_WINDOW];
  logic [CW-1:0] win_cnt_r, conf_idx_r;
  logic [1:0]    src_r;
  logic          confirming_r, src_conf_r;
  logic [15:0]   held_sample_r, held_base_r;
  logic          trig_r, chk_r, acc_r;
  logic          out_valid_r, out_trig_r, out_chk_r, out_acc_r;
  logic [15:0]   out_base_r;

  logic          accept, prox_en, ge, is_prox, start_w, start_c;
  logic [7:0]    icnt_p1;
  logic [CW-1:0] n_eff, conf_idx_p1, cnt0, cnt1;
  logic          app_req, app_clear, app_shift;
  logic [15:0]   app_data;
  logic          red_done, rise_red;
  logic [15:0]   red_result, rd_data;
  logic [AW-1:0] rd_addr;
  logic [1:0]    src_chk;
  logic          check_v;
  prtd_pkg::red_ctl_t red_ctl;

  function automatic logic rises(input logic [15:0] v, input logic [15:0] base,
                                 input logic [15:0] thr);
    rises = (v > base) && ((v - base) > thr);
  endfunction

  assign n_eff = (wsize_r == 5'd0) ? CW'(1) :
                 ((32'(wsize_r) > MAX_WINDOW) ? CW'(MAX_WINDOW) : CW'(wsize_r));

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign is_prox     = (in_if.mode == prtd_pkg::MODE_PROX);
  assign prox_en     = is_prox && (in_if.profile > prtd_pkg::PROF_MOTION);
  assign icnt_p1     = icnt_r + 8'd1;
  assign ge          = (icnt_p1 >= interval_r);
  assign conf_idx_p1 = conf_idx_r + 1'b1;
  assign start_w     = accept && prox_en && !confirming_r && ge && (win_cnt_r >= n_eff);
  assign start_c     = accept && prox_en && confirming_r && (conf_idx_p1 >= n_eff);
  assign rise_red    = rises(red_result, state_r == S_RUN_C ? held_base_r : held_sample_r,
                             thresh_r);

  assign red_ctl.start      = start_w || start_c;
  assign red_ctl.use_median = use_median_r;

  assign rd_data = src_conf_r ? conf_r[rd_addr] : win_r[rd_addr];

  prtd_reduce #(.MAX_WINDOW(MAX_WINDOW)) u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (red_ctl),
    .n       (n_eff),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (red_done),
    .result  (red_result)
  );

  // window append request
  always_comb begin
    app_req   = 1'b0;
    app_clear = 1'b0;
    app_data  = held_sample_r;
    if (accept && prox_en && !confirming_r && ge && (win_cnt_r < n_eff)) begin
      app_req  = 1'b1;
      app_data = in_if.sample;
    end else if (state_r == S_RUN_W && red_done) begin
      // red_result is the new baseline, compared against the held sample
      app_req = !rises(held_sample_r, red_result, thresh_r);
    end else if (state_r == S_RUN_C && red_done) begin
      app_req   = 1'b1;
      app_clear = rises(red_result, held_base_r, thresh_r);
    end
    cnt0      = app_clear ? '0 : win_cnt_r;
    app_shift = (cnt0 >= n_eff);
    cnt1      = app_shift ? n_eff - 1'b1 : cnt0;
  end

  always_comb begin
    src_chk = src_r | {1'b0, in_if.motion_seen};
    unique case (in_if.profile)
      prtd_pkg::PROF_MOTION: check_v = src_chk[0];
      prtd_pkg::PROF_PROX:   check_v = src_chk[1];
      prtd_pkg::PROF_EITHER: check_v = |src_chk;
      prtd_pkg::PROF_BOTH:   check_v = &src_chk;
      default:               check_v = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (app_req) begin
      if (app_shift) begin
        for (int k = 0; k < MAX_WINDOW - 1; k++) win_r[k] <= win_r[k+1];
      end
      if (32'(cnt1) < MAX_WINDOW) win_r[cnt1[AW-1:0]] <= app_data;
    end
    if (accept && prox_en && confirming_r && (32'(conf_idx_r) < MAX_WINDOW))
      conf_r[conf_idx_r[AW-1:0]] <= in_if.sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      interval_r    <= 8'd1;
      wsize_r       <= 5'd8;
      use_median_r  <= 1'b0;
      thresh_r      <= 16'd100;
      win_cnt_r     <= '0;
      conf_idx_r    <= '0;
      icnt_r        <= '0;
      src_r         <= '0;
      confirming_r  <= 1'b0;
      src_conf_r    <= 1'b0;
      held_sample_r <= '0;
      held_base_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          prtd_pkg::REG_INTERVAL:   interval_r   <= cfg_data[7:0];
          prtd_pkg::REG_WSIZE:      wsize_r      <= cfg_data[4:0];
          prtd_pkg::REG_USE_MEDIAN: use_median_r <= cfg_data[0];
          prtd_pkg::REG_THRESHOLD:  thresh_r     <= cfg_data;
          default: ;
        endcase
      end

      if (app_req) begin
        if (32'(cnt1) < MAX_WINDOW) win_cnt_r <= cnt1 + 1'b1;
        else                        win_cnt_r <= cnt1;
      end

      if (out_valid_r && out_if.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            trig_r  <= 1'b0;
            chk_r   <= 1'b0;
            acc_r   <= 1'b0;
            state_r <= S_EMIT;
            unique case (in_if.mode)
              prtd_pkg::MODE_PROX: begin
                if (prox_en) begin
                  if (confirming_r) begin
                    acc_r      <= 1'b1;
                    conf_idx_r <= conf_idx_p1;
                    if (start_c) begin
                      confirming_r <= 1'b0;
                      conf_idx_r   <= '0;
                      src_conf_r   <= 1'b1;
                      state_r      <= S_RUN_C;
                    end
                  end else begin
                    icnt_r <= icnt_p1;
                    if (ge) begin
                      icnt_r        <= '0;
                      acc_r         <= 1'b1;
                      held_sample_r <= in_if.sample;
                      if (start_w) begin
                        src_conf_r <= 1'b0;
                        state_r    <= S_RUN_W;
                      end
                    end
                  end
                end
              end
              prtd_pkg::MODE_CHECK: begin
                chk_r <= check_v;
                src_r <= '0;
              end
              prtd_pkg::MODE_CLEAR: begin
                win_cnt_r    <= '0;
                confirming_r <= 1'b0;
                conf_idx_r   <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RUN_W: begin
          if (red_done) begin
            held_base_r <= red_result;
            if (rises(held_sample_r, red_result, thresh_r)) begin
              confirming_r <= 1'b1;
              conf_idx_r   <= '0;
            end
            state_r <= S_EMIT;
          end
        end
        S_RUN_C: begin
          if (red_done) begin
            if (rise_red) begin
              trig_r   <= 1'b1;
              src_r[1] <= 1'b1;
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_trig_r  <= trig_r;
            out_chk_r   <= chk_r;
            out_acc_r   <= acc_r;
            out_base_r  <= held_base_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid               = out_valid_r;
  assign out_if.proximity_triggered = out_trig_r;
  assign out_if.check_result        = out_chk_r;
  assign out_if.sample_accepted     = out_acc_r;
  assign out_if.baseline            = out_base_r;

endmodule

### rtl/core/prtd_reduce.sv
// ----------------------------------------------------------------------------
// prtd_reduce
// Iterative window reduction: truncated mean (accumulate, then restoring
// divide) or median by rank counting with one shared comparator.
// ----------------------------------------------------------------------------
module prtd_reduce #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  prtd_pkg::red_ctl_t     ctl,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] n,
  output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] rd_addr,
  input  logic [15:0]            rd_data,
  output logic                   done,
  output logic [15:0]            result
);

  localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int SW  = 16 + CW;
  localparam int SCW = $clog2(SW);

  typedef enum logic [2:0] {R_IDLE, R_SUM, R_DIV, R_CAND, R_CMP} rstate_t;

  rstate_t        state_r;
  logic [AW-1:0]  i_r, j_r;
  logic [SW-1:0]  sum_r, dvd_r;
  logic [CW-1:0]  rem_r, lt_r, le_r;
  logic [SCW-1:0] step_r;
  logic [15:0]    cand_r, m1_r, m2_r, result_r;
  logic           done_r;

  logic [CW-1:0]  last, k1, k2, lt_n, le_n;
  logic [SW-1:0]  sum_n;
  logic [CW:0]    rem_w;
  logic           sub_ok, j_last, i_last;
  logic [15:0]    m1_n, m2_n;
  logic [16:0]    mid_sum;

  assign last   = n - 1'b1;
  assign k2     = n >> 1;
  assign k1     = n[0] ? k2 : k2 - 1'b1;
  assign j_last = (CW'(j_r) == last);
  assign i_last = (CW'(i_r) == last);
  assign sum_n  = sum_r + SW'(rd_data);
  assign rem_w  = {rem_r, dvd_r[SW-1]};
  assign sub_ok = (rem_w >= {1'b0, n});
  assign lt_n   = lt_r + CW'(rd_data < cand_r);
  assign le_n   = le_r + CW'(rd_data <= cand_r);
  assign m1_n   = (lt_n <= k1 && k1 < le_n) ? cand_r : m1_r;
  assign m2_n   = (lt_n <= k2 && k2 < le_n) ? cand_r : m2_r;
  assign mid_sum = {1'b0, m1_n} + {1'b0, m2_n};

  assign rd_addr = (state_r == R_CAND) ? i_r : j_r;
  assign done    = done_r;
  assign result  = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        R_IDLE: begin
          i_r   <= '0;
          j_r   <= '0;
          sum_r <= '0;
          if (ctl.start) state_r <= ctl.use_median ? R_CAND : R_SUM;
        end
        R_SUM: begin
          sum_r <= sum_n;
          j_r   <= j_r + 1'b1;
          if (j_last) begin
            dvd_r   <= sum_n;
            rem_r   <= '0;
            step_r  <= '0;
            state_r <= R_DIV;
          end
        end
        R_DIV: begin
          rem_r  <= sub_ok ? CW'(rem_w - {1'b0, n}) : rem_w[CW-1:0];
          dvd_r  <= {dvd_r[SW-2:0], sub_ok};
          step_r <= step_r + 1'b1;
          if (step_r == SCW'(SW - 1)) begin
            result_r <= {dvd_r[14:0], sub_ok};
            done_r   <= 1'b1;
            state_r  <= R_IDLE;
          end
        end
        R_CAND: begin
          cand_r  <= rd_data;
          lt_r    <= '0;
          le_r    <= '0;
          j_r     <= '0;
          state_r <= R_CMP;
        end
        R_CMP: begin
          lt_r <= lt_n;
          le_r <= le_n;
          j_r  <= j_r + 1'b1;
          if (j_last) begin
            m1_r <= m1_n;
            m2_r <= m2_n;
            i_r  <= i_r + 1'b1;
            if (i_last) begin
              result_r <= mid_sum[16:1];
              done_r   <= 1'b1;
              state_r  <= R_IDLE;
            end else begin
              state_r <= R_CAND;
            end
          end
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/prtd_checker.sv
// ----------------------------------------------------------------------------
// prtd_checker
// Port-level checks on the detector result channel, bound to the top level.
// ----------------------------------------------------------------------------
module prtd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic trig,
  input logic chk,
  input logic acc
);

  // a confirmed trigger only comes from a sample item
  a_trig_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && trig |-> acc && !chk)
    else $error("trigger without accepted sample");

  // check words and sample words never mix
  a_chk_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(chk && acc))
    else $error("check and sample flags together");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind proximity_rise_trigger_detector_top prtd_checker u_prtd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .trig      (out_if.proximity_triggered),
  .chk       (out_if.check_result),
  .acc       (out_if.sample_accepted)
);

### tb/sv/proximity_rise_trigger_detector_top_test.sv
// ----------------------------------------------------------------------------
// proximity_rise_trigger_detector_top_test
// Self-checking bench for the proximity rise trigger detector. A driver
// offers items from a queue with random gaps, a monitor takes result words
// with random stalls, and a behavioral predictor of window, divider,
// confirmation and trigger sources supplies the expected word for each item.
// ----------------------------------------------------------------------------
module proximity_rise_trigger_detector_top_test;

  localparam int MaxWin = 16;
  localparam int LongStallCycles = 200;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  profile;
    logic [15:0] sample;
    logic        motion_seen;
  } item_t;

  typedef struct packed {
    logic        triggered;
    logic        check;
    logic        accepted;
    logic [15:0] baseline;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = prtd_pkg::REG_INTERVAL;
  logic [15:0] cfg_data = '0;

  prtd_in_if  in_ch ();
  prtd_out_if out_ch ();

  proximity_rise_trigger_detector_top #(.MAX_WINDOW(MaxWin)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [7:0]  p_interval;
  logic [4:0]  p_wsize;
  logic        p_median;
  logic [15:0] p_thresh;
  logic [15:0] win_mem [MaxWin];
  logic [15:0] conf_mem [MaxWin];
  int          win_cnt, conf_idx;
  logic [7:0]  div_cnt;
  logic [1:0]  src_bits;
  logic        in_confirm;
  logic [15:0] held_smp, held_base;

  item_t pending_items[$];
  word_t expected_words[$];
  int    n_fail = 0;
  int    n_words = 0, n_trig = 0, n_checks_hi = 0;
  bit    hold_off = 1'b0;
  bit    stall_done = 1'b0;
  int    long_stall = 0;

  function automatic int eff_size();
    int n;
    n = p_wsize;
    if (n == 0) n = 1;
    if (n > MaxWin) n = MaxWin;
    return n;
  endfunction

  function automatic logic [15:0] window_figure(logic [15:0] src [MaxWin], int n);
    logic [15:0] srt [MaxWin];
    logic [15:0] v;
    logic [31:0] sum;
    int j;
    sum = 0;
    if (!p_median) begin
      for (int i = 0; i < n; i++) sum += src[i];
      return 16'(sum / n);
    end
    for (int i = 0; i < n; i++) begin
      v = src[i];
      j = i;
      while (j > 0 && srt[j-1] > v) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    if (n % 2) return srt[n/2];
    return 16'((32'(srt[n/2-1]) + srt[n/2]) / 2);
  endfunction

  function automatic bit rises_above(logic [15:0] v, logic [15:0] b);
    return v > b && 32'(v - b) > 32'(p_thresh);
  endfunction

  function automatic void push_held(int n);
    if (win_cnt >= n) begin
      win_cnt = n - 1;
      for (int i = 0; i < win_cnt; i++) win_mem[i] = win_mem[i+1];
    end
    if (win_cnt < MaxWin) begin
      win_mem[win_cnt] = held_smp;
      win_cnt++;
    end
  endfunction

  function automatic void predictor_reset();
    p_interval = 8'd1; p_wsize = 5'd8; p_median = 1'b0; p_thresh = 16'd100;
    win_cnt = 0; conf_idx = 0; div_cnt = 0; src_bits = 0; in_confirm = 0;
    held_smp = 0; held_base = 0;
  endfunction

  function automatic word_t predict_word(item_t it);
    word_t w;
    int n;
    logic [15:0] fig;
    w = '0;
    n = eff_size();
    if (it.mode == prtd_pkg::MODE_PROX) begin
      if (it.profile > prtd_pkg::PROF_MOTION) begin
        if (in_confirm) begin
          w.accepted = 1;
          if (conf_idx < MaxWin) conf_mem[conf_idx] = it.sample;
          conf_idx++;
          if (conf_idx >= n) begin
            fig = window_figure(conf_mem, n);
            in_confirm = 0;
            conf_idx = 0;
            if (rises_above(fig, held_base)) begin
              w.triggered = 1;
              src_bits |= 2'b10;
              win_cnt = 0;
            end
            push_held(n);
          end
        end else begin
          div_cnt = div_cnt + 8'd1;
          if (div_cnt >= p_interval) begin
            div_cnt = 0;
            w.accepted = 1;
            held_smp = it.sample;
            if (win_cnt >= n) begin
              held_base = window_figure(win_mem, n);
              if (rises_above(it.sample, held_base)) begin
                in_confirm = 1;
                conf_idx = 0;
              end else begin
                push_held(n);
              end
            end else begin
              push_held(n);
            end
          end
        end
      end
    end else if (it.mode == prtd_pkg::MODE_CHECK) begin
      if (it.motion_seen) src_bits |= 2'b01;
      case (it.profile)
        prtd_pkg::PROF_MOTION: w.check = src_bits[0];
        prtd_pkg::PROF_PROX:   w.check = src_bits[1];
        prtd_pkg::PROF_EITHER: w.check = |src_bits;
        prtd_pkg::PROF_BOTH:   w.check = &src_bits;
        default:               w.check = 1'b0;
      endcase
      src_bits = 0;
    end else if (it.mode == prtd_pkg::MODE_CLEAR) begin
      win_cnt = 0;
      in_confirm = 0;
      conf_idx = 0;
    end
    w.baseline = held_base;
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.mode        <= prtd_pkg::MODE_PROX;
      in_ch.profile     <= prtd_pkg::PROF_NONE;
      in_ch.sample      <= '0;
      in_ch.motion_seen <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_words.push_back(predict_word(pending_items.pop_front()));
      if (pending_items.size() > 0 && ($urandom_range(0, 3) != 0 || hold_off)) begin
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= pending_items[0].mode;
        in_ch.profile     <= pending_items[0].profile;
        in_ch.sample      <= pending_items[0].sample;
        in_ch.motion_seen <= pending_items[0].motion_seen;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver stall, counted while hold_off is up
  always @(posedge clk) begin
    if (!hold_off) begin
      long_stall <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done) begin
      if (long_stall >= LongStallCycles - 1) stall_done <= 1'b1;
      long_stall <= long_stall + 1;
    end
  end

  // monitor
  int stall_left = 0;
  always @(posedge clk) begin
    word_t got, exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.proximity_triggered, out_ch.check_result,
               out_ch.sample_accepted, out_ch.baseline};
        n_words++;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          n_fail++;
        end else begin
          exp_w = expected_words.pop_front();
          n_trig += exp_w.triggered;
          n_checks_hi += exp_w.check;
          if (got.triggered !== exp_w.triggered) begin
            $error("proximity_triggered exp %0d got %0d", exp_w.triggered, got.triggered);
            n_fail++;
          end
          if (got.check !== exp_w.check) begin
            $error("check_result exp %0d got %0d", exp_w.check, got.check);
            n_fail++;
          end
          if (got.accepted !== exp_w.accepted) begin
            $error("sample_accepted exp %0d got %0d", exp_w.accepted, got.accepted);
            n_fail++;
          end
          if (got.baseline !== exp_w.baseline) begin
            $error("baseline exp %0d got %0d", exp_w.baseline, got.baseline);
            n_fail++;
          end
        end
      end
      if (hold_off && !stall_done) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!hold_off && $urandom_range(0, 9) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                   : $urandom_range(1, 3);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      prtd_pkg::REG_INTERVAL:   p_interval = val[7:0];
      prtd_pkg::REG_WSIZE:      p_wsize = val[4:0];
      prtd_pkg::REG_USE_MEDIAN: p_median = val[0];
      default:                  p_thresh = val;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic item_t mk(logic [1:0] m, logic [2:0] p, logic [15:0] s, logic mo);
    item_t it;
    it.mode = m; it.profile = p; it.sample = s; it.motion_seen = mo;
    return it;
  endfunction

  // well-formed traffic: steady level, spike, confirming burst, checks, clears, unused items
  task automatic queue_random(int count);
    logic [15:0] level;
    int r;
    level = 16'($urandom_range(0, 60000));
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        pending_items.push_back(mk(prtd_pkg::MODE_PROX, 3'($urandom_range(2, 7)),
          ($urandom_range(0, 9) == 0) ? 16'($urandom)
          : 16'(level + $urandom_range(0, 40) + ($urandom_range(0, 5) == 0 ? 400 : 0)),
          1'($urandom)));
      else if (r < 82)
        pending_items.push_back(mk(prtd_pkg::MODE_CHECK, 3'($urandom), 16'($urandom),
                                   1'($urandom)));
      else if (r < 88)
        pending_items.push_back(mk(prtd_pkg::MODE_PROX, 3'($urandom_range(0, 1)),
                                   16'($urandom), 1'($urandom)));
      else if (r < 92)
        pending_items.push_back(mk(prtd_pkg::MODE_CLEAR, 3'($urandom), 16'($urandom),
                                   1'($urandom)));
      else if (r < 94)
        pending_items.push_back(mk(prtd_pkg::MODE_UNUSED, 3'($urandom), 16'($urandom),
                                   1'($urandom)));
      else
        level = 16'($urandom_range(0, 60000));
    end
  endtask

  initial begin
    predictor_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, fill window of 8, spike and confirm, checks, clear and unused items
    for (int i = 0; i < 8; i++)
      pending_items.push_back(mk(prtd_pkg::MODE_PROX, prtd_pkg::PROF_PROX, 16'd0, 0));
    pending_items.push_back(mk(prtd_pkg::MODE_PROX, 3'd7, 16'hFFFF, 1));
    for (int i = 0; i < 8; i++)
      pending_items.push_back(mk(prtd_pkg::MODE_PROX, prtd_pkg::PROF_EITHER, 16'hFFFF, 0));
    pending_items.push_back(mk(prtd_pkg::MODE_PROX, prtd_pkg::PROF_NONE, 16'hFFFF, 1));
    pending_items.push_back(mk(prtd_pkg::MODE_PROX, prtd_pkg::PROF_MOTION, 16'h1234, 1));
    pending_items.push_back(mk(prtd_pkg::MODE_CHECK, prtd_pkg::PROF_BOTH, 16'hFFFF, 1));
    pending_items.push_back(mk(prtd_pkg::MODE_CHECK, prtd_pkg::PROF_EITHER, 16'h0, 0));
    pending_items.push_back(mk(prtd_pkg::MODE_CHECK, 3'd6, 16'h0, 1));
    pending_items.push_back(mk(prtd_pkg::MODE_CLEAR, 3'd7, 16'hFFFF, 1));
    pending_items.push_back(mk(prtd_pkg::MODE_UNUSED, 3'd7, 16'hFFFF, 1));
    drain();

    // settings sweep: interval, size, reduction, threshold
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin
          write_reg(prtd_pkg::REG_INTERVAL, 16'd0); write_reg(prtd_pkg::REG_WSIZE, 16'd1);
          write_reg(prtd_pkg::REG_USE_MEDIAN, 16'd1);
          write_reg(prtd_pkg::REG_THRESHOLD, 16'd0);
        end
        1: begin
          write_reg(prtd_pkg::REG_INTERVAL, 16'd255); write_reg(prtd_pkg::REG_WSIZE, 16'd2);
          write_reg(prtd_pkg::REG_THRESHOLD, 16'hFFFF);
        end
        2: begin
          write_reg(prtd_pkg::REG_INTERVAL, 16'd1); write_reg(prtd_pkg::REG_WSIZE, 16'd16);
          write_reg(prtd_pkg::REG_USE_MEDIAN, 16'd0);
          write_reg(prtd_pkg::REG_THRESHOLD, 16'd100);
        end
        3: begin
          write_reg(prtd_pkg::REG_WSIZE, 16'd0); write_reg(prtd_pkg::REG_INTERVAL, 16'd2);
        end
        4: begin
          write_reg(prtd_pkg::REG_WSIZE, 16'd31); write_reg(prtd_pkg::REG_USE_MEDIAN, 16'd1);
          write_reg(prtd_pkg::REG_INTERVAL, 16'd1);
        end
        default: begin
          write_reg(prtd_pkg::REG_WSIZE, 16'($urandom_range(2, 9)));
          write_reg(prtd_pkg::REG_USE_MEDIAN, 16'($urandom_range(0, 1)));
          write_reg(prtd_pkg::REG_THRESHOLD, 16'($urandom_range(0, 300)));
          write_reg(prtd_pkg::REG_INTERVAL, 16'($urandom_range(0, 3)));
        end
      endcase
      if (ph == 5) begin
        // fill the pipe while the receiver stalls
        queue_random(40);
        hold_off = 1'b1;
        wait (stall_done);
        hold_off = 1'b0;
        queue_random(60);
      end else begin
        queue_random(ph == 1 ? 60 : 100);
      end
      drain();
    end

    $display("covered %0d words, %0d confirmed triggers, %0d true checks",
             n_words, n_trig, n_checks_hi);
    $display("over interval, window size, median/mean and threshold extremes");
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
